// File: sv/udrq_pkg.sv
// Shared types and constants for the dual ring queue.
package udrq_pkg;

  // Event codes carried on the input channel
  typedef enum logic [1:0] {
    CMD_RX_BYTE    = 2'd0,
    CMD_TX_READY   = 2'd1,
    CMD_HOST_READ  = 2'd2,
    CMD_HOST_WRITE = 2'd3
  } cmd_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_RESULT
  } state_t;

  localparam logic [7:0] END_OF_STRING = 8'h00;

endpackage

// File: sv/udrq_ring.sv
// One byte ring: synchronous store with head and tail pointers, one slot kept empty.
module udrq_ring #(
  parameter int DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       pop,
  input  logic [7:0] wdata,
  output logic [7:0] rdata,
  output logic       full,
  output logic       empty
);
  import udrq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;

  // Advance with wrap at the last entry
  assign head_next = (head == LAST) ? '0 : head + 1'b1;
  assign tail_next = (tail == LAST) ? '0 : tail + 1'b1;

  assign empty = (head == tail);
  assign full  = (head_next == tail);

  // Pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (push) head <= head_next;
      if (pop)  tail <= tail_next;
    end
  end

  // Store: write at head, registered read at tail
  always_ff @(posedge clk) begin
    if (push) mem[head] <= wdata;
    if (pop)  rdata <= mem[tail];
  end

endmodule

// File: sv/uart_dual_ring_queue_top.sv
// Top level of the dual ring queue: event decode, rings and result register.
//
// Usage:
//   Input channel (s_*): one event per transfer. s_tuser selects the event
//   (byte received, transmitter ready, host read, host write character) and
//   s_tdata carries the byte. Output channel (m_*): exactly one result per
//   event, in order. m_tuser marks a popped byte in m_tdata[7:0].
//   Each event is handled in ST_IDLE and then ST_RESULT: the accepting cycle
//   updates pointers and issues the ring access; ST_RESULT then picks up the
//   registered memory read data and loads the result register once it is free.
//   One event in flight at a time: the next is taken only after that load.
//   A result waits in the output register while the receiver stalls; the
//   next event is still taken and parks its result until the register frees.
//   Reset empties both rings (pointers to zero), clears the transmit enable
//   and the abort mark; no clearing pass over the stores is needed.
//   Each ring holds QUEUE_DEPTH entries and counts as full at QUEUE_DEPTH-1.
module uart_dual_ring_queue_top #(
  parameter int QUEUE_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_out, [8] dropped, [9] tx_irq_enabled,
                                 // [10] rx_empty, [11] tx_empty, [15:12] zero
  output logic        m_tuser    // [0] data_valid
);
  import udrq_pkg::*;

  state_t     state;
  state_t     state_next;
  cmd_t       cmd;
  logic       s_fire;
  logic       load_out;

  logic       rx_push, rx_pop, rx_full, rx_empty;
  logic       tx_push, tx_pop, tx_full, tx_empty;
  logic [7:0] rx_rdata, tx_rdata;

  logic       tx_enable;
  logic       string_aborted;
  logic       pend_valid;
  logic       pend_drop;
  logic       pend_tx;
  logic       drop_now;

  assign cmd    = cmd_t'(s_tuser);
  assign s_fire = s_tvalid && s_tready;

  udrq_ring #(.DEPTH(QUEUE_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (rx_push),
    .pop   (rx_pop),
    .wdata (s_tdata),
    .rdata (rx_rdata),
    .full  (rx_full),
    .empty (rx_empty)
  );

  udrq_ring #(.DEPTH(QUEUE_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .push  (tx_push),
    .pop   (tx_pop),
    .wdata (s_tdata),
    .rdata (tx_rdata),
    .full  (tx_full),
    .empty (tx_empty)
  );

  // Decode the event into ring accesses
  always_comb begin
    rx_push  = 1'b0;
    rx_pop   = 1'b0;
    tx_push  = 1'b0;
    tx_pop   = 1'b0;
    drop_now = 1'b0;
    if (s_fire) begin
      unique case (cmd)
        CMD_RX_BYTE: begin
          rx_push  = !rx_full;
          drop_now = rx_full;
        end
        CMD_TX_READY: begin
          tx_pop = tx_enable && !tx_empty;
        end
        CMD_HOST_READ: begin
          rx_pop = !rx_empty;
        end
        CMD_HOST_WRITE: begin
          if (s_tdata != END_OF_STRING) begin
            drop_now = string_aborted || tx_full;
            tx_push  = !string_aborted && !tx_full;
          end
        end
        default: begin
          drop_now = 1'b0;
        end
      endcase
    end
  end

  // Sequencer: take one event, then hand its result over
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        load_out = !m_tvalid || m_tready;
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Transmit enable and abort mark
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_enable      <= 1'b0;
      string_aborted <= 1'b0;
    end else if (s_fire) begin
      if (cmd == CMD_TX_READY && tx_enable && tx_empty) begin
        tx_enable <= 1'b0;
      end
      if (cmd == CMD_HOST_WRITE) begin
        if (s_tdata == END_OF_STRING) begin
          tx_enable      <= 1'b1;
          string_aborted <= 1'b0;
        end else if (!string_aborted && tx_full) begin
          string_aborted <= 1'b1;
        end
      end
    end
  end

  // Hold what the result stage needs from the accepting cycle
  always_ff @(posedge clk) begin
    if (s_fire) begin
      pend_valid <= rx_pop || tx_pop;
      pend_tx    <= tx_pop;
      pend_drop  <= drop_now;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata[7:0]   <= pend_valid ? (pend_tx ? tx_rdata : rx_rdata) : 8'h00;
      m_tdata[8]     <= pend_drop;
      m_tdata[9]     <= tx_enable;
      m_tdata[10]    <= rx_empty;
      m_tdata[11]    <= tx_empty;
      m_tdata[15:12] <= 4'h0;
      m_tuser        <= pend_valid;
    end
  end

endmodule
